@@ rtl/core/tcpq_pkg.sv @@
`default_nettype none

package tcpq_pkg;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_REMOVED  = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // one stored process record
    typedef struct packed {
        logic        is_system;
        logic [7:0]  prio_level;
        logic [15:0] proc_id;
        logic [15:0] burst_len;
    } proc_rec_t;

    localparam int REC_W = $bits(proc_rec_t);

    typedef logic [8:0] rank_key_t;

    // class bit above priority
    function automatic rank_key_t rank_key(input proc_rec_t rec);
        rank_key = {rec.is_system, rec.prio_level};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tcpq_ram.sv @@
`default_nettype none

module tcpq_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/two_class_priority_process_queue.sv @@
`default_nettype none

// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready | command, proc_id, burst_len, prio_level,
//         |           |                     | is_system
// out     | output    | out_valid/out_ready | status, out_proc_id, out_burst_len,
//         |           |                     | out_prio_level, out_is_system
//
// insert, full-queue insert and empty-queue remove: the result passes through the DONE state
// into the output register, and a new word is accepted only back in IDLE. a remove sweeps
// the single read port of the record memory once to find the winner (SCAN), once to close
// the gap (SHIFT), then passes through DONE.
// rst_n clears the fill count and the sequencer; the record memory needs no clearing.
// a result waiting on out_ready does not block the next accept; the sequencer stalls
// only when a new result is ready while the previous one is still held.

module two_class_priority_process_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [15:0] proc_id,
    input  wire logic [15:0] burst_len,
    input  wire logic [7:0]  prio_level,
    input  wire logic        is_system,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      out_proc_id,
    output logic [15:0]      out_burst_len,
    output logic [7:0]       out_prio_level,
    output logic             out_is_system
);

    import tcpq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    proc_rec_t        best_rec_reg, best_rec_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    proc_rec_t        out_rec_reg, out_rec_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [REC_W-1:0] ram_rdata;

    proc_rec_t        in_rec;
    proc_rec_t        rd_rec;
    logic             issue;

    assign in_rec = '{is_system: is_system, prio_level: prio_level,
                      proc_id: proc_id, burst_len: burst_len};
    assign rd_rec = proc_rec_t'(ram_rdata);

    tcpq_ram #(
        .WIDTH(REC_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // read sweep runs while the pointer is below the fill count
    assign issue = (ptr_reg < count_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        best_idx_next   = best_idx_reg;
        best_rec_next   = best_rec_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        out_rec_next    = out_rec_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IDX_W-1:0];
        ram_wdata       = in_rec;
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg[IDX_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DONE;
                    if (command == CMD_INSERT)
                    begin
                        if (count_reg < CNT_W'(QUEUE_DEPTH))
                        begin
                            ram_we          = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = STAT_INSERTED;
                        end
                        else
                        begin
                            res_status_next = STAT_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        res_status_next = STAT_REMOVED;
                        ptr_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read, compare the word read last cycle
                ram_re          = issue;
                pend_valid_next = issue;
                pend_idx_next   = ptr_reg[IDX_W-1:0];
                if (issue)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (pend_valid_reg)
                begin
                    if ((pend_idx_reg == '0) || (rank_key(rd_rec) > rank_key(best_rec_reg)))
                    begin
                        best_rec_next = rd_rec;
                        best_idx_next = pend_idx_reg;
                    end
                end
                if (!issue && !pend_valid_reg)
                begin
                    ptr_next   = CNT_W'(best_idx_reg) + CNT_W'(1);
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // move each later word down one slot over the winner
                ram_re          = issue;
                pend_valid_next = issue;
                pend_idx_next   = ptr_reg[IDX_W-1:0];
                if (issue)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (pend_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg - IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (!issue && !pend_valid_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    out_rec_next   = (res_status_reg == STAT_REMOVED) ? best_rec_reg : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload and pointers
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_rec_reg   <= best_rec_next;
        res_status_reg <= res_status_next;
        status_reg     <= status_next;
        out_rec_reg    <= out_rec_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_proc_id    = out_rec_reg.proc_id;
    assign out_burst_len  = out_rec_reg.burst_len;
    assign out_prio_level = out_rec_reg.prio_level;
    assign out_is_system  = out_rec_reg.is_system;

    // fill count stays within the memory
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

    // a search only starts on a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (count_reg != '0))
    else $error("search running on empty queue");

    // an accepted insert with room grows the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == CMD_INSERT) && (count_reg < CNT_W'(QUEUE_DEPTH)))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
    else $error("insert did not grow the queue");

    // only a removal carries a record
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STAT_REMOVED))
        |-> ((out_proc_id == '0) && (out_burst_len == '0) && (out_prio_level == '0)
             && !out_is_system))
    else $error("record fields set on a non-removal result");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import tcpq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_WORDS = 1000;
    localparam int PHASE_WORDS  = 50;

    // expected result word
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] proc_id;
        logic [15:0] burst_len;
        logic [7:0]  prio_level;
        logic        is_system;
    } sched_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = CMD_INSERT;
    logic [15:0] proc_id = '0;
    logic [15:0] burst_len = '0;
    logic [7:0]  prio_level = '0;
    logic        is_system = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [15:0] out_proc_id;
    logic [15:0] out_burst_len;
    logic [7:0]  out_prio_level;
    logic        out_is_system;

    // shadow of the held records, in arrival order
    proc_rec_t     held_recs[$];
    sched_result_t pending_results[$];

    int error_count = 0;
    int stall_cycles = 0;
    int rx_hold_req = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    two_class_priority_process_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .proc_id       (proc_id),
        .burst_len     (burst_len),
        .prio_level    (prio_level),
        .is_system     (is_system),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_proc_id   (out_proc_id),
        .out_burst_len (out_burst_len),
        .out_prio_level(out_prio_level),
        .out_is_system (out_is_system)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // scheduler prediction for one accepted command word
    function automatic sched_result_t schedule_step(input logic cmd, input proc_rec_t rec);
        sched_result_t res;
        int            best;
        logic [8:0]    best_key;
        logic [8:0]    cand_key;
        res = '0;
        if (cmd == CMD_INSERT)
        begin
            if (held_recs.size() >= DEPTH)
                res.status = STAT_FULL;
            else
            begin
                held_recs.push_back(rec);
                res.status = STAT_INSERTED;
            end
        end
        else if (held_recs.size() == 0)
            res.status = STAT_EMPTY;
        else
        begin
            // earliest record with the largest class/priority key wins
            best = 0;
            best_key = {held_recs[0].is_system, held_recs[0].prio_level};
            for (int i = 1; i < held_recs.size(); i++)
            begin
                cand_key = {held_recs[i].is_system, held_recs[i].prio_level};
                if (cand_key > best_key)
                begin
                    best_key = cand_key;
                    best = i;
                end
            end
            res.status     = STAT_REMOVED;
            res.proc_id    = held_recs[best].proc_id;
            res.burst_len  = held_recs[best].burst_len;
            res.prio_level = held_recs[best].prio_level;
            res.is_system  = held_recs[best].is_system;
            held_recs.delete(best);
        end
        return res;
    endfunction

    // offer one word and wait for its handshake
    task automatic send_word(input logic cmd, input logic [15:0] pid, input logic [15:0] blen,
                             input logic [7:0] prio, input logic sys);
        int        gap;
        proc_rec_t rec;
        gap = tx_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        proc_id    <= pid;
        burst_len  <= blen;
        prio_level <= prio;
        is_system  <= sys;
        do @(posedge clk); while (!in_ready);
        rec.is_system  = sys;
        rec.prio_level = prio;
        rec.proc_id    = pid;
        rec.burst_len  = blen;
        pending_results.push_back(schedule_step(cmd, rec));
    endtask

    // random word; priorities often drawn from a few values to force ties
    task automatic send_random(input int insert_pct);
        logic       cmd;
        logic [7:0] prio;
        cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        case ($urandom_range(0, 3))
            0:       prio = 8'd0;
            1:       prio = 8'd255;
            2:       prio = 8'($urandom_range(3, 5));
            default: prio = 8'($urandom);
        endcase
        send_word(cmd, 16'($urandom), 16'($urandom), prio, 1'($urandom));
    endtask

    // sender pause until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // empty remove, fill with extremes and ties, full insert, partial drain
    task automatic test_directed();
        send_word(CMD_REMOVE, 16'hffff, 16'hffff, 8'hff, 1'b1);
        send_word(CMD_INSERT, 16'h0000, 16'h0000, 8'd0, 1'b0);
        send_word(CMD_INSERT, 16'hffff, 16'hffff, 8'd255, 1'b1);
        send_word(CMD_INSERT, 16'h00a5, 16'h5a5a, 8'd255, 1'b0);
        send_word(CMD_INSERT, 16'h005a, 16'ha5a5, 8'd0, 1'b1);
        for (int i = 4; i < DEPTH; i++)
            send_word(CMD_INSERT, 16'h0100 + 16'(i), 16'($urandom), 8'd7, 1'(i));
        send_word(CMD_INSERT, 16'hdead, 16'hbeef, 8'd255, 1'b1);
        for (int i = 0; i < 6; i++)
            send_word(CMD_REMOVE, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // phases with varying insert bias so the fill level sweeps empty to full
    task automatic test_random();
        int insert_pct;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % PHASE_WORDS == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 20;
                    1:       insert_pct = 80;
                    default: insert_pct = 50;
                endcase
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_random(insert_pct);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        wait_drained();
        tx_idle_en = 1'b0;
        rx_hold_req = 80;
        for (int i = 0; i < 24; i++)
            send_random(75);
        wait_drained();
        rx_hold_req = 80;
        for (int i = 0; i < 24; i++)
            send_random(25);
        tx_idle_en = 1'b1;
    endtask

    // receiver ready pattern
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold_req) @(posedge clk);
                rx_hold_req = 0;
            end
            gap = rx_idle_en ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid && rx_hold_req == 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        sched_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected, status %0d", status);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.status)
                begin
                    $error("status expected %0d actual %0d", exp_res.status, status);
                    error_count++;
                end
                if (out_proc_id !== exp_res.proc_id)
                begin
                    $error("out_proc_id expected %0h actual %0h", exp_res.proc_id, out_proc_id);
                    error_count++;
                end
                if (out_burst_len !== exp_res.burst_len)
                begin
                    $error("out_burst_len expected %0h actual %0h",
                           exp_res.burst_len, out_burst_len);
                    error_count++;
                end
                if (out_prio_level !== exp_res.prio_level)
                begin
                    $error("out_prio_level expected %0d actual %0d",
                           exp_res.prio_level, out_prio_level);
                    error_count++;
                end
                if (out_is_system !== exp_res.is_system)
                begin
                    $error("out_is_system expected %0d actual %0d",
                           exp_res.is_system, out_is_system);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
